>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pfa_pkg.sv
// ---------------------------------------------------------------------------
// pfa_pkg
// Types and constants for the page frame allocator with directory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfa_pkg;

    // Operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Page directory geometry: slot = vaddr[31:22]
    localparam int DIR_SHIFT = 22;
    localparam int DIR_AW    = 10;
    localparam int DIR_SLOTS = 1 << DIR_AW;
    localparam logic [DIR_AW-1:0] DIR_MASK = 10'h3FF;
    localparam logic [DIR_AW-1:0] DIR_LAST = DIR_MASK;

    // Field widths of the result item
    localparam int OUT_FRAME_W = 5;
    localparam int OUT_COUNT_W = 6;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] virtual_address;
        logic [15:0] requested_frames;
    } t_in_item;

    typedef struct packed {
        logic                   ok;
        logic [OUT_FRAME_W-1:0] frame_index;
        logic [OUT_COUNT_W-1:0] free_frames;
    } t_out_item;

endpackage

>>> rtl/core/page_frame_allocator_with_directory.sv
// ---------------------------------------------------------------------------
// page_frame_allocator_with_directory
// First-fit frame allocator over a used-frame bitmap, with a 1024-slot page
// directory held in one synchronous single-port RAM.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------
//  in      | input     | i_in_valid / o_in_stall   | i_in_item
//  out     | output    | o_out_valid / i_out_stall | o_out_item
//
//  For each item, accept reads the directory slot; the execute state then
//  modifies it, writes it back and loads the result register.
//  After reset the directory is swept clear, one entry a cycle, with
//  o_in_stall high.
//  A full, stalled result register holds the execute state; the next item can
//  be accepted while a finished result waits to be taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module page_frame_allocator_with_directory
    import pfa_pkg::*;
#(
    parameter int FRAME_COUNT = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CW = $clog2(FRAME_COUNT + 1);
    localparam int DW = FW + 1;

    // Sequencer codes
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [DIR_AW-1:0]      r_clr_addr;
    logic [FRAME_COUNT-1:0] r_used, n_used;
    logic [CW-1:0]          r_count, n_count;
    logic [1:0]             r_op;
    logic [15:0]            r_req;
    logic [DIR_AW-1:0]      r_slot;
    logic [DW-1:0]          r_rd_entry;
    logic [DW-1:0]          r_dir [DIR_SLOTS];
    logic                   r_out_valid;
    t_out_item              r_out_item, n_out_item;

    logic                   w_accept;
    logic                   w_exec_go;
    logic [DIR_AW-1:0]      w_in_slot;
    logic                   w_any_free;
    logic [FW-1:0]          w_free_idx;
    logic                   w_ent_present;
    logic [FW-1:0]          w_ent_frame;
    logic                   w_dir_we;
    logic [DIR_AW-1:0]      w_dir_addr;
    logic [DW-1:0]          w_dir_data;
    logic                   w_exec_we;
    logic [DW-1:0]          w_exec_data;
    logic [31:0]            w_frame_wide;
    logic [31:0]            w_count_wide;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_exec_go  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign w_in_slot  = DIR_AW'(i_in_item.virtual_address >> DIR_SHIFT) & DIR_MASK;

    assign w_ent_present = r_rd_entry[DW-1];
    assign w_ent_frame   = r_rd_entry[FW-1:0];

    // Lowest free frame
    always_comb begin
        w_any_free = 1'b0;
        w_free_idx = '0;
        for (int k = FRAME_COUNT - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                w_any_free = 1'b1;
                w_free_idx = FW'(k);
            end
        end
    end

    // Operation: bitmap, count, directory write-back and result
    always_comb begin
        n_used       = r_used;
        n_count      = r_count;
        w_exec_we    = 1'b0;
        w_exec_data  = '0;
        w_frame_wide = '0;
        n_out_item   = '0;
        case (r_op)
            OP_ALLOC: begin
                if (w_any_free) begin
                    n_used[w_free_idx] = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                    w_exec_we     = 1'b1;
                    w_exec_data   = {1'b1, w_free_idx};
                    w_frame_wide  = 32'(w_free_idx);
                    n_out_item.ok = 1'b1;
                end
            end
            OP_FREE: begin
                if (w_ent_present) begin
                    if ((32'(w_ent_frame) < FRAME_COUNT) && r_used[w_ent_frame]) begin
                        n_used[w_ent_frame] = 1'b0;
                        if (32'(r_count) < FRAME_COUNT) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    w_exec_we     = 1'b1;
                    w_exec_data   = '0;
                    w_frame_wide  = 32'(w_ent_frame);
                    n_out_item.ok = 1'b1;
                end
            end
            OP_CHECK: begin
                n_out_item.ok = (32'(r_req) <= 32'(r_count));
            end
            default: begin
                n_out_item.ok = 1'b0;
            end
        endcase
        w_count_wide           = 32'(n_count);
        n_out_item.frame_index = w_frame_wide[OUT_FRAME_W-1:0];
        n_out_item.free_frames = w_count_wide[OUT_COUNT_W-1:0];
    end

    // Directory write port: clearing sweep or operation write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_dir_we   = 1'b1;
            w_dir_addr = r_clr_addr;
            w_dir_data = '0;
        end else begin
            w_dir_we   = w_exec_go && w_exec_we;
            w_dir_addr = r_slot;
            w_dir_data = w_exec_data;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == DIR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Directory RAM write
    always_ff @(posedge i_clk) begin
        if (w_dir_we) begin
            r_dir[w_dir_addr] <= w_dir_data;
        end
    end

    // Directory RAM read, registered; captured with the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_entry <= r_dir[w_in_slot];
            r_op       <= i_in_item.op;
            r_req      <= i_in_item.requested_frames;
            r_slot     <= w_in_slot;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_used      <= {{(FRAME_COUNT-1){1'b0}}, 1'b1};
            r_count     <= CW'(FRAME_COUNT - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + DIR_AW'(1);
            end
            if (w_exec_go) begin
                r_used      <= n_used;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `ASSERT_ALWAYS(a_count_matches_map, i_clk, i_rst_n, (32'($countones(r_used)) + 32'(r_count)) == 32'(FRAME_COUNT), "free count disagrees with used bitmap")
    `ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC, "accepted item did not enter execution")
    `ASSERT_IMPLY(a_result_from_exec, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_EXEC, "result appeared without an executed item")

endmodule
